// ----- rtl/bitmap_shape_transform_unit_macros.svh -----
// ---------------------------------------------------------------------------
// bitmap shape transform unit assertion macros
// concurrent check helpers used by rtl/bitmap_shape_transform_unit.sv
// ---------------------------------------------------------------------------
`ifndef BITMAP_SHAPE_TRANSFORM_UNIT_MACROS_SVH
`define BITMAP_SHAPE_TRANSFORM_UNIT_MACROS_SVH

// same-cycle implication
`define BST_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bst check failed");

// next-cycle implication
`define BST_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bst check failed");

`endif

// ----- rtl/bst_pkg.sv -----
// ---------------------------------------------------------------------------
// bitmap shape transform package
// beat types and function codes
// ---------------------------------------------------------------------------
package bst_pkg;

   localparam logic [3:0] FUNC_IDENT     = 4'd0;
   localparam logic [3:0] FUNC_ROT90     = 4'd1;
   localparam logic [3:0] FUNC_ROT180    = 4'd2;
   localparam logic [3:0] FUNC_ROT270    = 4'd3;
   localparam logic [3:0] FUNC_MIRROR    = 4'd4;
   localparam logic [3:0] FUNC_UP        = 4'd5;
   localparam logic [3:0] FUNC_LEFT      = 4'd6;
   localparam logic [3:0] FUNC_DOWN      = 4'd7;
   localparam logic [3:0] FUNC_RIGHT     = 4'd8;
   localparam logic [3:0] FUNC_NORMALIZE = 4'd9;

   typedef struct packed {
      logic [3:0]  func;
      logic [63:0] shape_bits;
   } bst_req_type;

   typedef struct packed {
      logic [63:0] result_bits;
      logic        ok;
   } bst_rsp_type;

endpackage

// ----- rtl/bst_normalize.sv -----
// ---------------------------------------------------------------------------
// bst normalizer
// moves a shape grid to the upper-left corner by its lowest used row/column when enable is high, else passes it through
// ---------------------------------------------------------------------------
module bst_normalize #(
   parameter int MAXD = 8
) (
   input  logic [MAXD-1:0][MAXD-1:0] grid_in,
   input  logic                      enable,
   output logic [MAXD-1:0][MAXD-1:0] grid_out
);

   localparam int CW = $clog2(MAXD);

   logic [MAXD-1:0]            col_occ;
   logic [MAXD-1:0]            row_occ;
   logic [CW-1:0]              col_min;
   logic [CW-1:0]              row_min;
   logic [CW-1:0]              col_sh;
   logic [CW-1:0]              row_sh;
   logic [MAXD-1:0][MAXD-1:0]  col_shifted;

   always_comb begin
      col_occ = '0;
      for (int b = 0; b < MAXD; b++) begin
         col_occ = col_occ | grid_in[b];
         row_occ[b] = |grid_in[b];
      end
   end

   // lowest occupied column and row
   always_comb begin
      col_min = '0;
      row_min = '0;
      for (int i = MAXD - 1; i >= 0; i--) begin
         if (col_occ[i]) begin
            col_min = CW'(i);
         end
         if (row_occ[i]) begin
            row_min = CW'(i);
         end
      end
   end

   assign col_sh = enable ? col_min : '0;
   assign row_sh = enable ? row_min : '0;

   always_comb begin
      for (int b = 0; b < MAXD; b++) begin
         col_shifted[b] = grid_in[b] >> col_sh;
      end
   end

   assign grid_out = col_shifted >> (row_sh * MAXD);

endmodule

// ----- rtl/bitmap_shape_transform_unit.sv -----
// ---------------------------------------------------------------------------
// bitmap shape transform unit
// rotates, mirrors, shifts and normalizes a shape bitmap on a grid
// ---------------------------------------------------------------------------
// usage:
//   req channel carries func and shape_bits, rsp channel carries
//   result_bits and ok; both are valid/ready.
//   a beat taken sits in the input register; its result is
//   computed in one pass of combinational logic and lands in the result
//   register when that register can advance, so rsp_valid rises once the
//   beat has moved on from the input register.
//   throughput is one beat per cycle while the receiver keeps up; the
//   transform logic has no loop or shared unit, so only the registers set it.
//   if the receiver stalls, the result register holds and the input
//   register still takes one more beat; req_ready drops only when both
//   registers are full and rsp_ready is low.
//   reset empties both registers; there is no other state.
//   unused func codes return ok low and zero bits.
// ---------------------------------------------------------------------------
`include "bitmap_shape_transform_unit_macros.svh"

module bitmap_shape_transform_unit
   import bst_pkg::*;
#(
   parameter int WIDTH  = 8,
   parameter int HEIGHT = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  bst_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output bst_rsp_type rsp_data
);

   localparam int MAXD  = (WIDTH > HEIGHT) ? WIDTH : HEIGHT;
   localparam int DIM   = (WIDTH < HEIGHT) ? WIDTH : HEIGHT;
   localparam int NCELL = (WIDTH * HEIGHT < 64) ? WIDTH * HEIGHT : 64;
   localparam logic [63:0] GRID_MASK =
      (NCELL == 64) ? {64{1'b1}} : ((64'd1 << NCELL) - 64'd1);

   typedef logic [MAXD-1:0][MAXD-1:0] grid_type;

   logic        s1_vld_ff, s1_vld_in;
   bst_req_type s1_req_ff, s1_req_in;
   logic        rsp_vld_ff, rsp_vld_in;
   bst_rsp_type rsp_ff, rsp_in;
   logic        out_adv;

   grid_type grid;
   grid_type st_r90, st_r180, st_r270, st_mir, st_up, st_lf, st_dn, st_rt;
   grid_type win_mask, dim_mask;
   grid_type sel_grid, nrm_a_in, nrm_a_grid, nrm_b_grid, res_grid;
   logic     norm_en, op_ok, edge_fail;
   logic     row_top, row_bot, col_lft, col_rgt;
   logic     fail_a, fail_b, fail_r90, is_r270, ok;
   logic [63:0] res_bits;

   // pipeline control
   assign out_adv   = !rsp_vld_ff || rsp_ready;
   assign req_ready = !s1_vld_ff || out_adv;

   assign s1_vld_in  = req_ready ? req_valid : s1_vld_ff;
   assign s1_req_in  = (req_valid && req_ready) ? req_data : s1_req_ff;
   assign rsp_vld_in = out_adv ? s1_vld_ff : rsp_vld_ff;
   assign rsp_in     = (out_adv && s1_vld_ff) ?
                       bst_rsp_type'{result_bits: res_bits, ok: ok} : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff <= s1_req_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // grid unpack and fixed permutations
   for (genvar gb = 0; gb < MAXD; gb++) begin : g_row
      for (genvar ga = 0; ga < MAXD; ga++) begin : g_col
         if (ga < WIDTH && gb < HEIGHT && gb * WIDTH + ga < 64) begin : g_in
            assign grid[gb][ga]     = s1_req_ff.shape_bits[gb * WIDTH + ga];
            assign win_mask[gb][ga] = 1'b1;
            assign dim_mask[gb][ga] = (ga < DIM && gb < DIM) ? 1'b1 : 1'b0;
         end else begin : g_out
            assign grid[gb][ga]     = 1'b0;
            assign win_mask[gb][ga] = 1'b0;
            assign dim_mask[gb][ga] = 1'b0;
         end

         if (ga < DIM && gb < DIM) begin : g_r90
            assign st_r90[gb][ga] = grid[ga][DIM-1-gb];
         end else begin : g_r90z
            assign st_r90[gb][ga] = 1'b0;
         end

         if (ga < WIDTH && gb < HEIGHT) begin : g_r180
            assign st_r180[gb][ga] = grid[HEIGHT-1-gb][WIDTH-1-ga];
         end else begin : g_r180z
            assign st_r180[gb][ga] = 1'b0;
         end

         if (ga < HEIGHT && gb < WIDTH) begin : g_r270
            assign st_r270[gb][ga] = grid[HEIGHT-1-ga][gb];
         end else begin : g_r270z
            assign st_r270[gb][ga] = 1'b0;
         end

         if (gb < HEIGHT) begin : g_mir
            assign st_mir[gb][ga] = grid[HEIGHT-1-gb][ga];
         end else begin : g_mirz
            assign st_mir[gb][ga] = 1'b0;
         end

         if (gb + 1 < MAXD) begin : g_up
            assign st_up[gb][ga] = grid[gb+1][ga];
         end else begin : g_upz
            assign st_up[gb][ga] = 1'b0;
         end

         if (ga + 1 < MAXD) begin : g_lf
            assign st_lf[gb][ga] = grid[gb][ga+1];
         end else begin : g_lfz
            assign st_lf[gb][ga] = 1'b0;
         end

         if (gb >= 1) begin : g_dn
            assign st_dn[gb][ga] = grid[gb-1][ga];
         end else begin : g_dnz
            assign st_dn[gb][ga] = 1'b0;
         end

         if (ga >= 1) begin : g_rt
            assign st_rt[gb][ga] = grid[gb][ga-1];
         end else begin : g_rtz
            assign st_rt[gb][ga] = 1'b0;
         end
      end
   end

   // edge occupancy for the one-cell shifts
   always_comb begin
      row_top = |grid[0];
      row_bot = |grid[HEIGHT-1];
      col_lft = 1'b0;
      col_rgt = 1'b0;
      for (int b = 0; b < MAXD; b++) begin
         col_lft = col_lft | grid[b][0];
         col_rgt = col_rgt | grid[b][WIDTH-1];
      end
   end

   always_comb begin
      sel_grid  = grid;
      norm_en   = 1'b0;
      op_ok     = 1'b1;
      edge_fail = 1'b0;
      unique case (s1_req_ff.func)
         FUNC_IDENT: begin
            sel_grid = grid;
         end
         FUNC_ROT90: begin
            sel_grid = st_r90;
            norm_en  = 1'b1;
         end
         FUNC_ROT180, FUNC_ROT270: begin
            sel_grid = st_r180;
            norm_en  = 1'b1;
         end
         FUNC_MIRROR: begin
            sel_grid = st_mir;
            norm_en  = 1'b1;
         end
         FUNC_UP: begin
            sel_grid  = st_up;
            edge_fail = row_top;
         end
         FUNC_LEFT: begin
            sel_grid  = st_lf;
            edge_fail = col_lft;
         end
         FUNC_DOWN: begin
            sel_grid  = st_dn;
            edge_fail = row_bot;
         end
         FUNC_RIGHT: begin
            sel_grid  = st_rt;
            edge_fail = col_rgt;
         end
         FUNC_NORMALIZE: begin
            sel_grid = grid;
            norm_en  = 1'b1;
         end
         default: begin
            op_ok = 1'b0;
         end
      endcase
   end

   assign nrm_a_in = sel_grid;

   bst_normalize #(
      .MAXD (MAXD)
   ) u_nrm_a (
      .grid_in  (nrm_a_in),
      .enable   (norm_en),
      .grid_out (nrm_a_grid)
   );

   // rotate 270 path, normalizes the rotate 270 permutation and is checked against the square dim mask
   bst_normalize #(
      .MAXD (MAXD)
   ) u_nrm_b (
      .grid_in  (st_r270),
      .enable   (1'b1),
      .grid_out (nrm_b_grid)
   );

   assign is_r270  = (s1_req_ff.func == FUNC_ROT270);
   assign fail_a   = |(nrm_a_grid & ~win_mask);
   assign fail_b   = is_r270 && (|(nrm_b_grid & ~dim_mask));
   assign fail_r90 = (s1_req_ff.func == FUNC_ROT90) && (|(grid & ~dim_mask));
   assign ok       = op_ok && !edge_fail && !fail_a && !fail_b && !fail_r90;
   assign res_grid = is_r270 ? nrm_b_grid : nrm_a_grid;

   // repack into bitmap order
   for (genvar gi = 0; gi < 64; gi++) begin : g_pack
      if (gi / WIDTH < HEIGHT) begin : g_cell
         assign res_bits[gi] = ok & res_grid[gi / WIDTH][gi % WIDTH];
      end else begin : g_none
         assign res_bits[gi] = 1'b0;
      end
   end

   `BST_ASSERT_IMPL(a_fail_zero, clock, reset,
      rsp_vld_ff && !rsp_ff.ok, rsp_ff.result_bits == 64'd0)
   `BST_ASSERT_IMPL(a_grid_only, clock, reset,
      rsp_vld_ff, (rsp_ff.result_bits & ~GRID_MASK) == 64'd0)
   `BST_ASSERT_NEXT(a_take_fills, clock, reset,
      req_valid && req_ready, s1_vld_ff)
   `BST_ASSERT_NEXT(a_stage_moves, clock, reset,
      s1_vld_ff && !rsp_vld_ff, rsp_vld_ff)
   `BST_ASSERT_IMPL(a_bad_code, clock, reset,
      s1_vld_ff && (s1_req_ff.func > FUNC_NORMALIZE), !ok)

endmodule
